@@ src/rssf_pkg.sv @@
package rssf_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam int unsigned WIDTH_REG_W  = 11;
	localparam int unsigned HEIGHT_REG_W = 13;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic MODE_SHARPEN = 1'b0;
	localparam logic MODE_SMOOTH  = 1'b1;

	// Geometry.
	localparam int unsigned MIN_DIM        = 3;
	localparam int unsigned INTERIOR_START = 2;

	// Arithmetic.
	localparam int unsigned SAMPLE_W    = 8;
	localparam int unsigned NUM_CH      = 3;
	localparam int unsigned SHARP_W     = 12;
	localparam int unsigned SUM_W       = 12;
	localparam int unsigned SHARP_GAIN  = 5;
	localparam int unsigned SAMPLE_MAX  = 255;
	localparam int unsigned RECIP9      = 7282;
	localparam int unsigned RECIP_SHIFT = 16;
	localparam int unsigned PROD_W      = 25;

	// Output queue.
	localparam int unsigned OUTQ_DEPTH = 8;
	localparam int unsigned QPTR_W     = $clog2(OUTQ_DEPTH);
	localparam int unsigned QCNT_W     = $clog2(OUTQ_DEPTH + 1);

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t red;
		sample_t green;
		sample_t blue;
	} pixel_t;

	typedef pixel_t [2:0] pix_trio_t;
	typedef pix_trio_t [2:0] window_t;

	typedef struct packed {
		logic valid;
		logic frame_last;
	} tag_t;

	typedef struct packed {
		sample_t red;
		sample_t green;
		sample_t blue;
		logic    frame_last;
	} result_t;

	function automatic sample_t chan(input pixel_t p, input int unsigned ch);
		sample_t s;
		case (ch)
			0:       s = p.red;
			1:       s = p.green;
			default: s = p.blue;
		endcase
		return s;
	endfunction

endpackage

@@ src/rssf_calc.sv @@
module rssf_calc import rssf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    mode,
	input  window_t win,
	input  tag_t    tag_in,
	output logic    res_valid,
	output result_t res
);

	logic signed [SHARP_W-1:0] sharp_s3 [NUM_CH];
	logic [SUM_W-1:0]          sum_s3   [NUM_CH];
	tag_t                      tag_s3;
	sample_t                   ch_out   [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else begin
			tag_s3 <= tag_in;
		end
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
		logic [SUM_W-1:0]   sum_c;
		logic [SHARP_W-1:0] sharp_c;
		logic [PROD_W-1:0]  prod;

		always_comb begin
			sum_c = '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					sum_c = sum_c + SUM_W'(chan(win[r][c], ch));
				end
			end
			// Wraps modulo 2^12; the true value always fits the signed range.
			sharp_c = SHARP_W'(chan(win[1][1], ch)) * SHARP_W'(SHARP_GAIN)
				- SHARP_W'(chan(win[0][1], ch)) - SHARP_W'(chan(win[2][1], ch))
				- SHARP_W'(chan(win[1][0], ch)) - SHARP_W'(chan(win[1][2], ch));
		end

		always_ff @(posedge clk) begin
			sum_s3[ch]   <= sum_c;
			sharp_s3[ch] <= $signed(sharp_c);
		end

		// Division by nine as a multiply by a rounded-up reciprocal; the error
		// stays far below one step for any sum of nine samples.
		always_comb begin
			prod = PROD_W'(sum_s3[ch]) * PROD_W'(RECIP9);
			if (mode == MODE_SMOOTH) begin
				ch_out[ch] = SAMPLE_W'(prod >> RECIP_SHIFT);
			end else if (sharp_s3[ch][SHARP_W-1]) begin
				ch_out[ch] = '0;
			end else if (sharp_s3[ch] > $signed(SHARP_W'(SAMPLE_MAX))) begin
				ch_out[ch] = SAMPLE_W'(SAMPLE_MAX);
			end else begin
				ch_out[ch] = SAMPLE_W'(sharp_s3[ch]);
			end
		end
	end

	assign res_valid      = tag_s3.valid;
	assign res.red        = ch_out[0];
	assign res.green      = ch_out[1];
	assign res.blue       = ch_out[2];
	assign res.frame_last = tag_s3.frame_last;

endmodule

@@ src/rssf_outq.sv @@
module rssf_outq import rssf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  result_t           push_word,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           out_word,
	output logic [QCNT_W-1:0] count
);

	result_t           slots [OUTQ_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_word  = slots[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == OUTQ_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == OUTQ_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/rgb_3x3_sharpen_smooth_filter.sv @@
// Channel   Handshake              Word
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
// in        in_valid/in_ready      red_in, green_in, blue_in
// out       out_valid/out_ready    red_out, green_out, blue_out, frame_last
//
// One pixel is taken per cycle while in_ready is high; the line memories are read at
// acceptance and written back in the next cycle, so consecutive pixels never touch
// the same entry. A result passes the stage-one, window and calc registers and is then
// pushed into the output queue; out_valid shows it right after. Reset clears counters,
// window and queue and loads the default geometry; the line memories need no clearing.
// in_ready drops when queued plus in-flight results would fill the 8-word output queue.
module rgb_3x3_sharpen_smooth_filter import rssf_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            red_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            blue_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out,
	output logic                  frame_last
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);

	logic                    mode_q;
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;

	logic [31:0]   width_cl;
	logic [31:0]   height_cl;
	logic [CW-1:0] last_col;
	logic [RW-1:0] last_row;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          in_acc;
	logic          at_last_col;
	logic          at_last_row;

	pixel_t        upper_mem  [MAX_WIDTH];
	pixel_t        middle_mem [MAX_WIDTH];
	pixel_t        up_s1;
	pixel_t        mid_s1;
	pixel_t        px_s1;
	logic [CW-1:0] col_s1;
	logic          v_s1;
	logic          emit_s1;
	logic          last_s1;

	window_t win_q;
	tag_t    tag_s2;

	logic              res_valid;
	result_t           res;
	result_t           q_word;
	logic [QCNT_W-1:0] q_count;

	// Configuration.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SHARPEN;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FILTER_MODE:  mode_q   <= cfg_data[0];
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		width_cl = 32'(width_q);
		if (width_cl < MIN_DIM) width_cl = MIN_DIM;
		if (width_cl > MAX_WIDTH) width_cl = MAX_WIDTH;
		height_cl = 32'(height_q);
		if (height_cl < MIN_DIM) height_cl = MIN_DIM;
		if (height_cl > MAX_HEIGHT) height_cl = MAX_HEIGHT;
	end

	assign last_col = CW'(width_cl - 32'd1);
	assign last_row = RW'(height_cl - 32'd1);

	// Input credit covers every result already queued or still in flight.
	assign in_ready = (32'(q_count) + 32'(v_s1 && emit_s1) + 32'(tag_s2.valid)
		+ 32'(res_valid)) < OUTQ_DEPTH;
	assign in_acc      = in_valid && in_ready;
	assign at_last_col = (col_q >= last_col);
	assign at_last_row = (row_q >= last_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Line memories: read on acceptance, written back from stage one.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			up_s1  <= upper_mem[col_q];
			mid_s1 <= middle_mem[col_q];
		end
		if (v_s1) begin
			upper_mem[col_s1]  <= mid_s1;
			middle_mem[col_s1] <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1   <= '{red: red_in, green: green_in, blue: blue_in};
			col_s1  <= col_q;
			emit_s1 <= (32'(row_q) >= INTERIOR_START) && (32'(col_q) >= INTERIOR_START);
			last_s1 <= at_last_row && at_last_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			tag_s2 <= '0;
			win_q  <= '0;
		end else begin
			v_s1         <= in_acc;
			tag_s2.valid <= v_s1 && emit_s1;
			tag_s2.frame_last <= last_s1;
			if (v_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= up_s1;
				win_q[1][2] <= mid_s1;
				win_q[2][2] <= px_s1;
			end
		end
	end

	rssf_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.win       (win_q),
		.tag_in    (tag_s2),
		.res_valid (res_valid),
		.res       (res)
	);

	rssf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_word (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (q_word),
		.count     (q_count)
	);

	assign red_out    = q_word.red;
	assign green_out  = q_word.green;
	assign blue_out   = q_word.blue;
	assign frame_last = q_word.frame_last;

endmodule
